@@ hdl/jqc_pkg.sv @@
`default_nettype none
package jqc_pkg;

	localparam int QUEUE_SLOTS = 16;
	localparam int PTR_W = $clog2(QUEUE_SLOTS);
	localparam int TAG_W = 32;
	localparam int PAGES_W = 16;
	localparam int ENTRY_W = TAG_W + PAGES_W;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 3;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;
	localparam logic [PAGES_W-1:0] MAX_PAGES_RESET = PAGES_W'(50);
	localparam logic [PADDR_W-3:0] REG_MAX_PAGES = '0;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ    = 2'd0,
		KIND_DEQ    = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_PAGES    = 3'd2,
		STS_EMPTY    = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ_CAP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_W-1:0]    out_tag;
		logic [PAGES_W-1:0]  out_pages;
	} result_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(QUEUE_SLOTS - 1) : p - PTR_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ hdl/job_queue_with_cancel.sv @@
// Circular job queue of QUEUE_SLOTS-1 usable entries (tag, page count) held in one
// single-port-read RAM, run by a small sequencer that handles one beat at a time.
// Enqueue, clear and cancel on an empty queue finish in the execute state; dequeue
// adds a capture state for the RAM read data; other cancels compare entries from
// the oldest and, on a hit, move each later entry forward; the one RAM read port
// is used once per compare or move. A new beat is taken once the previous result
// sits in the output register. No clearing pass after reset; clear only resets the
// pointers.
`default_nettype none
module job_queue_with_cancel
	import jqc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [ENTRY_W-1:0]   s_tdata,   // job_tag, page_count
	input  wire logic [KIND_W-1:0]    s_tuser,   // kind
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [ENTRY_W-1:0]   m_tdata,   // out_tag, out_pages
	output logic      [STATUS_W-1:0]  m_tuser,   // status
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [PDATA_W-1:0]   pwdata,
	output logic      [PDATA_W-1:0]   prdata,
	output logic                      pready
);

	logic [PAGES_W-1:0] max_pages_q;
	logic               reg_sel;
	logic               m_valid_q;
	result_t            m_res_q;
	logic               out_free;
	logic               res_valid;
	result_t            res;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_MAX_PAGES);
	assign prdata  = reg_sel ? PDATA_W'(max_pages_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q <= MAX_PAGES_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_pages_q <= pwdata[PAGES_W-1:0];
		end
	end

	assign out_free = !m_valid_q || m_tready;

	jqc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (kind_t'(s_tuser)),
		.in_tag   (s_tdata[TAG_W-1:0]),
		.in_pages (s_tdata[ENTRY_W-1:TAG_W]),
		.max_pages(max_pages_q),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_res_q.out_pages, m_res_q.out_tag};
	assign m_tuser  = m_res_q.status;

endmodule
`default_nettype wire

@@ hdl/jqc_ram.sv @@
`default_nettype none
module jqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ hdl/jqc_seq.sv @@
`default_nettype none
module jqc_seq
	import jqc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire kind_t              in_kind,
	input  wire logic [TAG_W-1:0]   in_tag,
	input  wire logic [PAGES_W-1:0] in_pages,
	input  wire logic [PAGES_W-1:0] max_pages,
	input  wire logic               out_free,
	output logic                    res_valid,
	output result_t                 res
);

	state_t               state_q, state_d;
	logic [PTR_W-1:0]     rp_q, rp_d, wp_q, wp_d, idx_q, idx_d;
	kind_t                kind_q;
	logic [TAG_W-1:0]     tag_q;
	logic [PAGES_W-1:0]   pages_q;
	result_t              res_q, res_d;
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_addr, rd_addr;
	logic [ENTRY_W-1:0]   wr_data, rd_data;
	logic [PTR_W-1:0]     nxt_idx, wp_prev;
	logic                 empty, tag_hit;

	jqc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_SLOTS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign nxt_idx = next_ptr(idx_q);
	assign wp_prev = prev_ptr(wp_q);
	assign empty   = (rp_q == wp_q);
	assign tag_hit = (rd_data[TAG_W-1:0] == tag_q);
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			wp_q    <= '0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_q <= res_d;
		if (in_valid && in_ready) begin
			kind_q  <= in_kind;
			tag_q   <= in_tag;
			pages_q <= in_pages;
		end
	end

	always_comb begin
		state_d   = state_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		idx_d     = idx_q;
		res_d     = res_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rd_data;
		rd_addr   = rp_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_d   = '{status: STS_OK, out_tag: '0, out_pages: '0};
				idx_d   = rp_q;
				state_d = ST_DONE;
				unique case (kind_q)
					KIND_ENQ: begin
						if (next_ptr(wp_q) == rp_q) begin
							res_d.status = STS_FULL;
						end else if (pages_q > max_pages) begin
							res_d.status = STS_PAGES;
						end else begin
							wr_en   = 1'b1;
							wr_addr = wp_q;
							wr_data = {pages_q, tag_q};
							wp_d    = next_ptr(wp_q);
						end
					end
					KIND_DEQ: begin
						if (empty) begin
							res_d.status = STS_EMPTY;
						end else begin
							rp_d    = next_ptr(rp_q);
							state_d = ST_DEQ_CAP;
						end
					end
					KIND_CANCEL: begin
						if (empty) begin
							res_d.status = STS_EMPTY;
						end else begin
							state_d = ST_SRCH_CMP;
						end
					end
					KIND_CLEAR: begin
						rp_d = '0;
						wp_d = '0;
					end
					default: ;
				endcase
			end
			ST_DEQ_CAP: begin
				res_d.out_tag   = rd_data[TAG_W-1:0];
				res_d.out_pages = rd_data[ENTRY_W-1:TAG_W];
				state_d         = ST_DONE;
			end
			ST_SRCH_RD: begin
				rd_addr = idx_q;
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (tag_hit) begin
					if (nxt_idx == wp_q) begin
						wp_d    = wp_prev;
						state_d = ST_DONE;
					end else begin
						state_d = ST_SHIFT_RD;
					end
				end else begin
					idx_d = nxt_idx;
					if (nxt_idx == wp_q) begin
						res_d.status = STS_NOTFOUND;
						state_d      = ST_DONE;
					end else begin
						state_d = ST_SRCH_RD;
					end
				end
			end
			ST_SHIFT_RD: begin
				rd_addr = nxt_idx;
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				wr_en = 1'b1;
				idx_d = nxt_idx;
				if (nxt_idx == wp_prev) begin
					wp_d    = wp_prev;
					state_d = ST_DONE;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: ;
		endcase
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= PTR_W'(QUEUE_SLOTS - 1) && wp_q <= PTR_W'(QUEUE_SLOTS - 1))
		else $error("queue pointer out of range");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q != ST_IDLE && state_q != ST_DONE)
		else $error("store written outside an operation");

	a_rp_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EXEC |=> $stable(rp_q))
		else $error("read pointer moved outside execute");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != STS_OK |-> res.out_tag == '0 && res.out_pages == '0)
		else $error("nonzero payload on failed operation");

endmodule
`default_nettype wire

@@ bench/jqc_checker.sv @@
`timescale 1ns / 1ps
module jqc_checker
	import jqc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [ENTRY_W-1:0]   s_tdata,   // job_tag, page_count
	input  wire logic [KIND_W-1:0]    s_tuser,   // kind
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [ENTRY_W-1:0]   m_tdata,   // out_tag, out_pages
	input  wire logic [STATUS_W-1:0]  m_tuser,   // status
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [PDATA_W-1:0]   pwdata,
	input  wire logic                 pready,
	output int                        fail_count,
	output int                        outstanding
);

	logic [TAG_W-1:0]   queue_tags [QUEUE_SLOTS];
	logic [PAGES_W-1:0] queue_pages [QUEUE_SLOTS];
	logic [PTR_W-1:0]   head;
	logic [PTR_W-1:0]   tail;
	logic [PAGES_W-1:0] page_limit;
	result_t            expected_results [$];

	function automatic logic [PTR_W-1:0] fwd(input logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + 1) % QUEUE_SLOTS);
	endfunction

	function automatic logic [PTR_W-1:0] back(input logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + QUEUE_SLOTS - 1) % QUEUE_SLOTS);
	endfunction

	function automatic void wipe_queue();
		for (int n = 0; n < QUEUE_SLOTS; n++) begin
			queue_tags[n] = '0;
			queue_pages[n] = '0;
		end
		head = '0;
		tail = '0;
	endfunction

	function automatic result_t run_job(input kind_t k, input logic [TAG_W-1:0] tg,
			input logic [PAGES_W-1:0] pg);
		result_t          r;
		logic [PTR_W-1:0] i;
		logic [PTR_W-1:0] j;
		logic [PTR_W-1:0] nxt;
		logic             hit;
		r.status = STS_OK;
		r.out_tag = '0;
		r.out_pages = '0;
		hit = 1'b0;
		case (k)
			KIND_ENQ: begin
				if (fwd(tail) == head) begin
					r.status = STS_FULL;
				end else if (pg > page_limit) begin
					r.status = STS_PAGES;
				end else begin
					queue_tags[tail] = tg;
					queue_pages[tail] = pg;
					tail = fwd(tail);
				end
			end
			KIND_DEQ: begin
				if (head == tail) begin
					r.status = STS_EMPTY;
				end else begin
					r.out_tag = queue_tags[head];
					r.out_pages = queue_pages[head];
					head = fwd(head);
				end
			end
			KIND_CANCEL: begin
				if (head == tail) begin
					r.status = STS_EMPTY;
				end else begin
					r.status = STS_NOTFOUND;
					i = head;
					while (i != tail && !hit) begin
						if (queue_tags[i] == tg) begin
							// first match from the oldest end; close the gap
							hit = 1'b1;
							j = i;
							while (j != tail) begin
								nxt = fwd(j);
								queue_tags[j] = queue_tags[nxt];
								queue_pages[j] = queue_pages[nxt];
								j = nxt;
							end
							tail = back(tail);
							r.status = STS_OK;
						end else begin
							i = fwd(i);
						end
					end
				end
			end
			default: begin
				wipe_queue();
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : sample
		result_t want;
		if (!arst_n) begin
			wipe_queue();
			page_limit = MAX_PAGES_RESET;
			expected_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_MAX_PAGES) begin
				page_limit = pwdata[PAGES_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(run_job(kind_t'(s_tuser), s_tdata[TAG_W-1:0],
					s_tdata[ENTRY_W-1:TAG_W]));
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: status %0d tag %h pages %0d",
						$time, m_tuser, m_tdata[TAG_W-1:0], m_tdata[ENTRY_W-1:TAG_W]);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_tuser);
						fail_count++;
					end
					if (m_tdata[TAG_W-1:0] !== want.out_tag) begin
						$display("%0t: out_tag expected %h actual %h",
							$time, want.out_tag, m_tdata[TAG_W-1:0]);
						fail_count++;
					end
					if (m_tdata[ENTRY_W-1:TAG_W] !== want.out_pages) begin
						$display("%0t: out_pages expected %0d actual %0d",
							$time, want.out_pages, m_tdata[ENTRY_W-1:TAG_W]);
						fail_count++;
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import jqc_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SEGMENT_JOBS   = 385;
	localparam int TAG_POOL       = 12;
	localparam int END_DRAIN      = 2 * QUEUE_SLOTS + 3 + 8;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [ENTRY_W-1:0]  s_tdata = '0;   // job_tag, page_count
	logic [KIND_W-1:0]   s_tuser = '0;   // kind
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [ENTRY_W-1:0]  m_tdata;        // out_tag, out_pages
	logic [STATUS_W-1:0] m_tuser;        // status
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int                  fail_count;
	int                  outstanding;
	int                  send_idle = 0;
	int                  recv_idle = 0;
	logic                hold_req = 1'b0;
	int                  hold_left = 0;
	int                  idle_cycles = 0;
	int                  n_kind [4] = '{0, 0, 0, 0};
	logic [PAGES_W-1:0]  limit_now = MAX_PAGES_RESET;
	logic [TAG_W-1:0]    tag_pool [TAG_POOL];

	always #1 clk = ~clk;

	job_queue_with_cancel i_dut (.*);

	jqc_checker i_checker (.*);

	// output side: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	task automatic send_job(input kind_t k, input logic [TAG_W-1:0] tg,
			input logic [PAGES_W-1:0] pg);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {pg, tg};
		do @(posedge clk); while (!s_tready);
		n_kind[int'(k)]++;
	endtask

	task automatic park_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		park_input();
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_limit(input logic [PAGES_W-1:0] v);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_MAX_PAGES, 2'b00};
		pwdata <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		limit_now = v;
	endtask

	task automatic random_job(input int enq_pct);
		int                 roll;
		int                 top_pages;
		kind_t              k;
		logic [TAG_W-1:0]   tg;
		logic [PAGES_W-1:0] pg;
		roll = $urandom_range(0, 99);
		if (roll < enq_pct) k = KIND_ENQ;
		else if (roll < enq_pct + (98 - enq_pct) / 2) k = KIND_DEQ;
		else if (roll < 98) k = KIND_CANCEL;
		else k = KIND_CLEAR;
		// small tag pool so cancels hit and duplicates occur
		if ($urandom_range(0, 99) < 85) tg = tag_pool[$urandom_range(0, TAG_POOL - 1)];
		else tg = $urandom;
		top_pages = (int'(limit_now) + 2 > 65535) ? 65535 : int'(limit_now) + 2;
		if ($urandom_range(0, 5) == 0) pg = PAGES_W'($urandom_range(0, 65535));
		else pg = PAGES_W'($urandom_range(0, top_pages));
		send_job(k, tg, pg);
	endtask

	task automatic run_segment(input int s_idle, input int r_idle,
			input logic [PAGES_W-1:0] lim, input bit stress);
		write_limit(lim);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int n = 0; n < SEGMENT_JOBS; n++) begin
			if (stress && n == 100) hold_req = 1'b1;
			if (stress && n == 200) wait_drained();
			// alternate between filling and draining the queue
			random_job(((n / 60) % 2 == 1) ? 30 : 62);
		end
	endtask

	initial begin
		for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		send_job(KIND_DEQ, '1, '1);
		send_job(KIND_CANCEL, '0, '0);
		send_job(KIND_ENQ, '0, MAX_PAGES_RESET);
		send_job(KIND_ENQ, 32'h1, MAX_PAGES_RESET + 1'b1);
		send_job(KIND_ENQ, '1, '0);
		for (int i = 0; i < 13; i++) send_job(KIND_ENQ, tag_pool[i % 4], PAGES_W'(i));
		send_job(KIND_ENQ, '1, '1);
		send_job(KIND_DEQ, '0, '0);
		// wraps into the last slot, so every slot has been written
		send_job(KIND_ENQ, 32'hA5A5_A5A5, 16'd7);
		send_job(KIND_CANCEL, 32'h1234_5678, '0);
		send_job(KIND_CANCEL, tag_pool[1], '0);
		send_job(KIND_CANCEL, 32'hA5A5_A5A5, '0);
		send_job(KIND_CANCEL, '1, '0);
		send_job(KIND_DEQ, '0, '0);
		send_job(KIND_CLEAR, '1, '1);
		send_job(KIND_DEQ, '0, '0);

		run_segment(10, 88, 16'hFFFF, 1'b1);
		run_segment(88, 10, 16'h0000, 1'b0);
		run_segment(0, 0, PAGES_W'($urandom_range(1, 65534)), 1'b1);
		run_segment(0, 0, PAGES_W'($urandom_range(1, 300)), 1'b0);

		wait_drained();
		repeat (END_DRAIN) @(negedge clk);

		$display("Ran %0d enqueue, %0d dequeue, %0d cancel and %0d clear jobs",
			n_kind[KIND_ENQ], n_kind[KIND_DEQ], n_kind[KIND_CANCEL], n_kind[KIND_CLEAR]);
		$display("Page limits 50, 65535, 0 and two random; three stall profiles, hold-off, drain");
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, outstanding);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
